FILE: hw/rtl/tssd_pkg.sv
// Shared types and constants for the temperature sensor scratchpad decoder.
package tssd_pkg;

    // Frame layout of the scratchpad.
    localparam int unsigned FRAME_BYTES = 9;
    localparam logic [3:0] IDX_TEMP_LOW  = 4'd0;
    localparam logic [3:0] IDX_TEMP_HIGH = 4'd1;
    localparam logic [3:0] IDX_RESERVED  = 4'd5;
    localparam logic [3:0] IDX_LAST      = 4'(FRAME_BYTES - 1);

    // Reflected CRC-8 constants (x8+x5+x4+1).
    localparam logic [7:0] CRC_XOR  = 8'h18;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] RESERVED_VALUE = 8'hFF;

    // Sign field patterns of the raw temperature word.
    localparam logic [4:0] SIGN_POS = 5'h00;
    localparam logic [4:0] SIGN_NEG = 5'h1f;

    // Limit register reset values, in tenths of a degree.
    localparam logic signed [11:0] UPPER_LIMIT_RESET = 12'sd1000;
    localparam logic signed [11:0] LOWER_LIMIT_RESET = -12'sd550;

    // Configuration register indexes.
    localparam logic REG_UPPER_LIMIT = 1'b0;
    localparam logic REG_LOWER_LIMIT = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_RESERVED_BAD = 3'd1;
    localparam logic [2:0] ST_CRC_ERROR    = 3'd2;
    localparam logic [2:0] ST_SIGN_BAD     = 3'd3;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

    // One input byte of the scratchpad.
    typedef struct packed {
        logic       frame_start;
        logic [7:0] byte_value;
    } item_t;

    // One decoded reading.
    typedef struct packed {
        logic [2:0]        read_status;
        logic signed [11:0] temp_tenths;
    } result_t;

    // Frame contents handed to the evaluator on the last byte.
    typedef struct packed {
        logic [7:0] temp_low;
        logic [7:0] temp_high;
        logic       reserved_ok;
        logic [7:0] crc;
    } frame_t;

endpackage

FILE: hw/rtl/tssd_frame_eval.sv
// Final evaluation of a complete scratchpad frame: status and temperature.
module tssd_frame_eval (
    input  tssd_pkg::frame_t   frame,
    input  logic signed [11:0] upper_limit,
    input  logic signed [11:0] lower_limit,
    output tssd_pkg::result_t  result
);

    logic [7:0]         half;
    logic [4:0]         sign;
    logic signed [11:0] half_ext;
    logic signed [11:0] temp_x5;
    logic               out_of_range;

    // Half-degree count with its sign taken from bit 11 of the raw word.
    assign half     = {frame.temp_high[2:0], frame.temp_low[7:3]};
    assign sign     = frame.temp_high[7:3];
    assign half_ext = {{3{frame.temp_high[3]}}, frame.temp_high[3], half};

    // Times five as a shift and an add.
    assign temp_x5      = {half_ext[9:0], 2'b00} + half_ext;
    assign out_of_range = (temp_x5 >= upper_limit) || (temp_x5 < lower_limit);

    // The lowest fault code wins; the temperature is zero on any fault.
    always_comb
    begin
        result.read_status = tssd_pkg::ST_OK;
        result.temp_tenths = '0;
        if (!frame.reserved_ok)
        begin
            result.read_status = tssd_pkg::ST_RESERVED_BAD;
        end
        else if (frame.crc != 8'h00)
        begin
            result.read_status = tssd_pkg::ST_CRC_ERROR;
        end
        else if (sign != tssd_pkg::SIGN_POS && sign != tssd_pkg::SIGN_NEG)
        begin
            result.read_status = tssd_pkg::ST_SIGN_BAD;
        end
        else if (out_of_range)
        begin
            result.read_status = tssd_pkg::ST_OUT_OF_RANGE;
        end
        else
        begin
            result.temp_tenths = temp_x5;
        end
    end

endmodule

FILE: hw/rtl/temp_sensor_scratchpad_decoder.sv
// Top level of the temperature sensor scratchpad decoder.
// The block takes one scratchpad byte per cycle while no result is blocked and
// produces one reading after the ninth byte of each frame. A byte passes an
// input register and then combinational logic (a full CRC-8 byte step, and on
// the last byte the status and times-five evaluation) into the result
// register; the whole CRC byte step between the two registers sets the rate of
// one byte per cycle. The input side keeps taking bytes while a result waits,
// until the input register itself is blocked. The user must write the limit
// registers through the plain write port only while idle; nothing enforces it.
module temp_sensor_scratchpad_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tssd_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output tssd_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [11:0]        cfg_data
);

    logic                      s1_valid_reg;
    tssd_pkg::item_t           s1_item_reg;
    logic [3:0]                byte_count_reg;
    logic [3:0]                byte_count_next;
    logic [7:0]                crc_reg;
    logic [7:0]                crc_next;
    logic [7:0]                temp_low_reg;
    logic [7:0]                temp_high_reg;
    logic                      reserved_ok_reg;
    logic signed [11:0]        upper_limit_reg;
    logic signed [11:0]        lower_limit_reg;
    logic                      result_valid_reg;
    tssd_pkg::result_t         result_reg;
    tssd_pkg::result_t         eval_result;
    tssd_pkg::frame_t          frame;
    logic                      stage_go;
    logic                      step;
    logic [3:0]                idx;
    logic                      last_byte;

    // One reflected CRC-8 byte step, bit by bit.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = ((c ^ tssd_pkg::CRC_XOR) >> 1) | tssd_pkg::CRC_TOP;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // Handshake: the stage moves when the result register is free or being emptied.
    assign stage_go     = !result_valid_reg || result_ready;
    assign step         = s1_valid_reg && stage_go;
    assign item_ready   = !s1_valid_reg || stage_go;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Position of the byte in its frame; a start mark or a bad count restarts.
    always_comb
    begin
        if (s1_item_reg.frame_start || byte_count_reg >= 4'(tssd_pkg::FRAME_BYTES))
        begin
            idx = '0;
        end
        else
        begin
            idx = byte_count_reg;
        end
        last_byte       = (idx == tssd_pkg::IDX_LAST);
        byte_count_next = last_byte ? 4'd0 : idx + 4'd1;
        crc_next        = crc8_step((idx == 4'd0) ? 8'h00 : crc_reg, s1_item_reg.byte_value);
    end

    // Temperature bytes are already latched by the time the last byte arrives.
    assign frame.temp_low    = temp_low_reg;
    assign frame.temp_high   = temp_high_reg;
    assign frame.reserved_ok = reserved_ok_reg;
    assign frame.crc         = crc_next;

    tssd_frame_eval u_eval (
        .frame       (frame),
        .upper_limit (upper_limit_reg),
        .lower_limit (lower_limit_reg),
        .result      (eval_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    // Frame state: counter, CRC and latched bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            crc_reg         <= '0;
            temp_low_reg    <= '0;
            temp_high_reg   <= '0;
            reserved_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            if (idx == tssd_pkg::IDX_TEMP_LOW)
            begin
                temp_low_reg <= s1_item_reg.byte_value;
            end
            if (idx == tssd_pkg::IDX_TEMP_HIGH)
            begin
                temp_high_reg <= s1_item_reg.byte_value;
            end
            if (idx == tssd_pkg::IDX_RESERVED)
            begin
                reserved_ok_reg <= (s1_item_reg.byte_value == tssd_pkg::RESERVED_VALUE);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            result_valid_reg <= step && last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_byte)
        begin
            result_reg <= eval_result;
        end
    end

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= tssd_pkg::UPPER_LIMIT_RESET;
            lower_limit_reg <= tssd_pkg::LOWER_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tssd_pkg::REG_UPPER_LIMIT: upper_limit_reg <= cfg_data;
                tssd_pkg::REG_LOWER_LIMIT: lower_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The counter never leaves the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < 4'(tssd_pkg::FRAME_BYTES))
        else $error("byte counter outside the frame");

    // A finished frame leaves the counter at zero and a result pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> byte_count_reg == 4'd0 && result_valid_reg)
        else $error("frame end did not restart the counter or raise a result");

    // A faulted reading carries a zero temperature.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.read_status != tssd_pkg::ST_OK
        |-> result_reg.temp_tenths == 12'sd0)
        else $error("nonzero temperature with a fault status");

    // A blocked result stalls the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready && s1_valid_reg |-> !item_ready)
        else $error("input taken while the stage is blocked");

endmodule

FILE: verif/tb_temp_sensor_scratchpad_decoder.sv
// Self-checking testbench for the temperature sensor scratchpad decoder.
module tb_temp_sensor_scratchpad_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 125;
    localparam int PHASE_COUNT    = 7;
    localparam int IDLE_PERCENT   = 17;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTS     = 40;

    // Kinds of scratchpad traffic that the random part builds.
    typedef enum int {
        FK_GOOD,
        FK_RESERVED_BAD,
        FK_CRC_BAD,
        FK_SIGN_BAD,
        FK_RESTART,
        FK_NOISE
    } frame_kind_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    tssd_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    tssd_pkg::result_t result;
    logic              cfg_we       = 1'b0;
    logic              cfg_index    = tssd_pkg::REG_UPPER_LIMIT;
    logic [11:0]       cfg_data     = '0;

    // Traffic shaping shared by the initial block and the clocked processes.
    logic steady        = 1'b0;
    int   hold_requests = 0;
    int   hold_served;
    int   hold_left;

    tssd_pkg::item_t   byte_queue[$];
    tssd_pkg::result_t pending_readings[$];
    logic [7:0] frame_buf[tssd_pkg::FRAME_BYTES];

    // Predictor copy of the limits and of the frame state.
    logic [11:0] upper_lim      = tssd_pkg::UPPER_LIMIT_RESET;
    logic [11:0] lower_lim      = tssd_pkg::LOWER_LIMIT_RESET;
    logic [3:0]  sp_count       = '0;
    logic [7:0]  sp_crc         = '0;
    logic [7:0]  sp_low         = '0;
    logic [7:0]  sp_high        = '0;
    logic        sp_reserved_ok = 1'b0;

    int error_count   = 0;
    int bytes_queued  = 0;
    int bytes_sent    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    int status_seen[5];

    temp_sensor_scratchpad_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One reflected CRC-8 byte step, LSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        int k;
        c = crc_in;
        d = data_in;
        for (k = 0; k < 8; k++)
        begin
            if (c[0] ^ d[0])
                c = ((c ^ tssd_pkg::CRC_XOR) >> 1) | tssd_pkg::CRC_TOP;
            else
                c = c >> 1;
            d = d >> 1;
        end
        return c;
    endfunction

    // Advances the predicted frame state by one byte; returns 1 when a reading is due.
    function automatic bit decode_scratchpad_byte(input tssd_pkg::item_t in_byte,
                                                  output tssd_pkg::result_t reading);
        logic [3:0] idx;
        logic [7:0] crc_next;
        logic [7:0] half;
        logic [4:0] sign;
        logic [2:0] status;
        int tenths;
        reading = '0;
        idx = (in_byte.frame_start || sp_count >= tssd_pkg::FRAME_BYTES)
              ? tssd_pkg::IDX_TEMP_LOW : sp_count;
        crc_next = crc8_step((idx == tssd_pkg::IDX_TEMP_LOW) ? 8'h00 : sp_crc,
                             in_byte.byte_value);
        sp_crc = crc_next;
        if (idx == tssd_pkg::IDX_TEMP_LOW)
            sp_low = in_byte.byte_value;
        else if (idx == tssd_pkg::IDX_TEMP_HIGH)
            sp_high = in_byte.byte_value;
        else if (idx == tssd_pkg::IDX_RESERVED)
            sp_reserved_ok = (in_byte.byte_value == tssd_pkg::RESERVED_VALUE);
        if (int'(idx) + 1 < tssd_pkg::FRAME_BYTES)
        begin
            sp_count = idx + 4'd1;
            return 1'b0;
        end
        sp_count = '0;

        // Last byte: work out the status in priority order and the temperature.
        half = {sp_high[2:0], sp_low[7:3]};
        sign = sp_high[7:3];
        tenths = 0;
        if (!sp_reserved_ok)
            status = tssd_pkg::ST_RESERVED_BAD;
        else if (crc_next != 8'h00)
            status = tssd_pkg::ST_CRC_ERROR;
        else if (sign != tssd_pkg::SIGN_POS && sign != tssd_pkg::SIGN_NEG)
            status = tssd_pkg::ST_SIGN_BAD;
        else
        begin
            if (sign == tssd_pkg::SIGN_POS)
                tenths = int'(half) * 5;
            else
                tenths = (int'(half) - 256) * 5;
            if (tenths >= int'($signed(upper_lim)) || tenths < int'($signed(lower_lim)))
                status = tssd_pkg::ST_OUT_OF_RANGE;
            else
                status = tssd_pkg::ST_OK;
        end
        if (status != tssd_pkg::ST_OK)
            tenths = 0;
        reading.read_status = status;
        reading.temp_tenths = tenths[11:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Sender: offers queued bytes, idling at random unless traffic is steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (byte_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                item       <= byte_queue.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off each time one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_served  <= 0;
            hold_left    <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES - 1;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor: checks each result transfer, predicts from each byte transfer,
    // and stops the run if nothing moves for too long.
    always @(posedge clk)
    begin
        tssd_pkg::result_t reading;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_readings.size() == 0)
                    report_mismatch($sformatf("unexpected reading, status %0d temp %0d",
                                              result.read_status, result.temp_tenths));
                else
                begin
                    reading = pending_readings.pop_front();
                    if (result.read_status !== reading.read_status)
                        report_mismatch($sformatf("read_status %0d, predicted %0d",
                                                  result.read_status, reading.read_status));
                    if (result.temp_tenths !== reading.temp_tenths)
                        report_mismatch($sformatf("temp_tenths %0d, predicted %0d",
                                                  result.temp_tenths, reading.temp_tenths));
                    status_seen[reading.read_status]++;
                end
            end
            if (item_valid && item_ready)
            begin
                bytes_sent++;
                if (decode_scratchpad_byte(item, reading))
                    pending_readings.push_back(reading);
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_temp_sensor_scratchpad_decoder: done, errors");
                $finish;
            end
        end
    end

    // Writes one limit register and mirrors it into the predictor.
    task automatic write_limit(input logic which, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value[11:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (which == tssd_pkg::REG_UPPER_LIMIT)
            upper_lim = value[11:0];
        else
            lower_lim = value[11:0];
    endtask

    task automatic set_limits(input int upper, input int lower);
        write_limit(tssd_pkg::REG_UPPER_LIMIT, upper);
        write_limit(tssd_pkg::REG_LOWER_LIMIT, lower);
        settings_used++;
    endtask

    // Waits until every byte is sent and every reading has come back, and checks
    // again after a settling wait.
    task automatic drain();
        do
        begin
            while (byte_queue.size() != 0 || item_valid || pending_readings.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (byte_queue.size() != 0 || item_valid || pending_readings.size() != 0);
    endtask

    task automatic push_byte(input logic start, input logic [7:0] value);
        tssd_pkg::item_t b;
        b.frame_start = start;
        b.byte_value  = value;
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic start, input int count);
        int i;
        for (i = 0; i < count; i++)
            push_byte((i == 0) ? start : 1'b0, frame_buf[i]);
    endtask

    // Fills frame_buf with a scratchpad of the given half-degree count and fault.
    task automatic build_frame(input int half_s, input frame_kind_t kind);
        logic [15:0] raw;
        logic [7:0]  c;
        int i;
        raw[2:0] = 3'($urandom_range(7));
        if (half_s < 0)
        begin
            raw[10:3]  = 8'(half_s + 256);
            raw[15:11] = tssd_pkg::SIGN_NEG;
        end
        else
        begin
            raw[10:3]  = 8'(half_s);
            raw[15:11] = tssd_pkg::SIGN_POS;
        end
        if (kind == FK_SIGN_BAD)
            raw[15:11] = 5'($urandom_range(30, 1));
        frame_buf[0] = raw[7:0];
        frame_buf[1] = raw[15:8];
        for (i = 2; i < tssd_pkg::FRAME_BYTES - 1; i++)
            frame_buf[i] = 8'($urandom_range(255));
        frame_buf[tssd_pkg::IDX_RESERVED] = (kind == FK_RESERVED_BAD)
                                            ? 8'($urandom_range(254))
                                            : tssd_pkg::RESERVED_VALUE;
        c = 8'h00;
        for (i = 0; i < tssd_pkg::FRAME_BYTES - 1; i++)
            c = crc8_step(c, frame_buf[i]);
        frame_buf[tssd_pkg::IDX_LAST] = c;
        // A single flipped bit always breaks the CRC.
        if (kind == FK_CRC_BAD)
            frame_buf[$urandom_range(tssd_pkg::FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
    endtask

    // Half-degree count: mostly uniform, sometimes at or next to a limit.
    function automatic int pick_half();
        int h;
        if ($urandom_range(3) == 0)
        begin
            if ($urandom_range(1) == 0)
                h = int'($signed(upper_lim)) / 5;
            else
                h = int'($signed(lower_lim)) / 5;
            h = h + int'($urandom_range(2)) - 1;
        end
        else
            h = int'($urandom_range(511)) - 256;
        if (h > 255)
            h = 255;
        if (h < -256)
            h = -256;
        return h;
    endfunction

    task automatic random_traffic();
        int roll;
        int n;
        int i;
        frame_kind_t kind;
        roll = $urandom_range(99);
        if (roll < 60)
            kind = FK_GOOD;
        else if (roll < 70)
            kind = FK_RESERVED_BAD;
        else if (roll < 80)
            kind = FK_CRC_BAD;
        else if (roll < 88)
            kind = FK_SIGN_BAD;
        else if (roll < 95)
            kind = FK_RESTART;
        else
            kind = FK_NOISE;

        case (kind)
            FK_NOISE:
            begin
                n = $urandom_range(12, 1);
                for (i = 0; i < n; i++)
                    push_byte($urandom_range(7) == 0, 8'($urandom_range(255)));
            end
            FK_RESTART:
            begin
                // A broken-off frame, then a full one that restarts with the start flag.
                build_frame(pick_half(), FK_GOOD);
                push_frame(1'($urandom_range(1)), $urandom_range(tssd_pkg::FRAME_BYTES - 1, 1));
                build_frame(pick_half(), FK_GOOD);
                push_frame(1'b1, tssd_pkg::FRAME_BYTES);
            end
            default:
            begin
                build_frame(pick_half(), kind);
                push_frame($urandom_range(4) != 0, tssd_pkg::FRAME_BYTES);
            end
        endcase
    endtask

    // Stimulus: directed frames, then phases of random traffic under different limits.
    initial
    begin
        int phase;
        int phase_start;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: warmest reading without a start flag after reset, a frame
        // broken off by a restart, then the coldest reading.
        set_limits(1280, -1280);
        build_frame(255, FK_GOOD);
        push_frame(1'b0, tssd_pkg::FRAME_BYTES);
        build_frame(-3, FK_GOOD);
        push_frame(1'b1, 4);
        build_frame(-256, FK_GOOD);
        push_frame(1'b1, tssd_pkg::FRAME_BYTES);
        drain();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_limits(1280, -1280);
                1: set_limits(int'(tssd_pkg::UPPER_LIMIT_RESET),
                              int'(tssd_pkg::LOWER_LIMIT_RESET));
                2: set_limits(-1280, 1280);
                3: set_limits(0, -5);
                4: set_limits(5 * int'($urandom_range(512)) - 1280,
                              5 * int'($urandom_range(512)) - 1280);
                5: set_limits(int'($urandom_range(2560)) - 1280,
                              int'($urandom_range(2560)) - 1280);
                default: set_limits(1280, -1280);
            endcase
            // Phase 5 runs with no idling at all; phase 6 starts with a long
            // receiver hold-off while the sender keeps offering bytes.
            steady <= (phase == 5);
            if (phase == PHASE_COUNT - 1)
                hold_requests <= hold_requests + 1;
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                random_traffic();
            drain();
        end

        if (pending_readings.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
        $display("run covered %0d bytes under %0d limit settings", bytes_sent, settings_used);
        $display("readings: ok %0d, reserved %0d, crc %0d, sign %0d, range %0d",
                 status_seen[tssd_pkg::ST_OK], status_seen[tssd_pkg::ST_RESERVED_BAD],
                 status_seen[tssd_pkg::ST_CRC_ERROR], status_seen[tssd_pkg::ST_SIGN_BAD],
                 status_seen[tssd_pkg::ST_OUT_OF_RANGE]);
        if (error_count == 0)
            $display("tb_temp_sensor_scratchpad_decoder: done, clean");
        else
            $display("tb_temp_sensor_scratchpad_decoder: done, errors");
        $finish;
    end

endmodule
